// ----- rtl/dsm_pkg.sv -----
// ----------------------------------------------------------------------------
// dsm_pkg
// shared codes and control structs of the stack machine execution unit
// ----------------------------------------------------------------------------
package dsm_pkg;

	localparam int unsigned CMD_W  = 5;
	localparam int unsigned DATA_W = 64;
	localparam int unsigned CNT_W  = 7;
	localparam int unsigned STS_W  = 2;

	localparam logic [CMD_W-1:0] OP_PUSH  = 5'd0;
	localparam logic [CMD_W-1:0] OP_DUP   = 5'd1;
	localparam logic [CMD_W-1:0] OP_DROP  = 5'd2;
	localparam logic [CMD_W-1:0] OP_OVER  = 5'd3;
	localparam logic [CMD_W-1:0] OP_PICK  = 5'd4;
	localparam logic [CMD_W-1:0] OP_SWAP  = 5'd5;
	localparam logic [CMD_W-1:0] OP_ROT   = 5'd6;
	localparam logic [CMD_W-1:0] OP_ABS   = 5'd7;
	localparam logic [CMD_W-1:0] OP_AND   = 5'd8;
	localparam logic [CMD_W-1:0] OP_DIV   = 5'd9;
	localparam logic [CMD_W-1:0] OP_MINUS = 5'd10;
	localparam logic [CMD_W-1:0] OP_MOD   = 5'd11;
	localparam logic [CMD_W-1:0] OP_MUL   = 5'd12;
	localparam logic [CMD_W-1:0] OP_NEG   = 5'd13;
	localparam logic [CMD_W-1:0] OP_NOT   = 5'd14;
	localparam logic [CMD_W-1:0] OP_OR    = 5'd15;
	localparam logic [CMD_W-1:0] OP_PLUS  = 5'd16;
	localparam logic [CMD_W-1:0] OP_PLUSU = 5'd17;
	localparam logic [CMD_W-1:0] OP_SHL   = 5'd18;
	localparam logic [CMD_W-1:0] OP_SHR   = 5'd19;
	localparam logic [CMD_W-1:0] OP_SHRA  = 5'd20;
	localparam logic [CMD_W-1:0] OP_XOR   = 5'd21;
	localparam logic [CMD_W-1:0] OP_BRA   = 5'd22;
	localparam logic [CMD_W-1:0] OP_EQ    = 5'd23;
	localparam logic [CMD_W-1:0] OP_GE    = 5'd24;
	localparam logic [CMD_W-1:0] OP_GT    = 5'd25;
	localparam logic [CMD_W-1:0] OP_LE    = 5'd26;
	localparam logic [CMD_W-1:0] OP_LT    = 5'd27;
	localparam logic [CMD_W-1:0] OP_NE    = 5'd28;
	localparam logic [CMD_W-1:0] OP_CLEAR = 5'd29;
	localparam logic [CMD_W-1:0] OP_RSV0  = 5'd30;
	localparam logic [CMD_W-1:0] OP_RSV1  = 5'd31;

	localparam logic [STS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STS_W-1:0] ST_DIVZ  = 2'd1;
	localparam logic [STS_W-1:0] ST_UNDER = 2'd2;
	localparam logic [STS_W-1:0] ST_OVER  = 2'd3;

	localparam logic [CNT_W-1:0] LIMIT_RST = 7'd64;

	typedef struct packed {
		logic accept;
		logic md_start;
		logic commit;
	} dsm_cmd_t;

	typedef struct packed {
		logic md_op;
		logic err;
		logic md_done;
		logic out_free;
	} dsm_stat_t;

endpackage

// ----- rtl/dsm_in_if.sv -----
// ----------------------------------------------------------------------------
// dsm_in_if
// instruction channel: command and immediate
// ----------------------------------------------------------------------------
interface dsm_in_if;
	logic        valid;
	logic        ready;
	logic [4:0]  command;
	logic [63:0] immediate;

	modport source (output valid, command, immediate, input ready);
	modport sink (input valid, command, immediate, output ready);
endinterface

// ----- rtl/dsm_out_if.sv -----
// ----------------------------------------------------------------------------
// dsm_out_if
// result channel: top, depth, branch flag and status
// ----------------------------------------------------------------------------
interface dsm_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] top_value;
	logic [6:0]  stack_count;
	logic        branch_taken;
	logic [1:0]  status;

	modport source (output valid, top_value, stack_count, branch_taken, status, input ready);
	modport sink (input valid, top_value, stack_count, branch_taken, status, output ready);
endinterface

// ----- rtl/dsm_cfg_if.sv -----
// ----------------------------------------------------------------------------
// dsm_cfg_if
// configuration write channel for the stack limit
// ----------------------------------------------------------------------------
interface dsm_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- rtl/dsm_muldiv.sv -----
// ----------------------------------------------------------------------------
// dsm_muldiv
// sequential 64-bit multiply (three 32x32 products) and radix-2 divide
// ----------------------------------------------------------------------------
module dsm_muldiv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [4:0]  op,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] result
);
	import dsm_pkg::*;

	logic        busy_q;
	logic        mul_q;
	logic        mod_q;
	logic        neg_q;
	logic [6:0]  cnt_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] quo_q;
	logic [63:0] rem_q;
	logic [63:0] prod_q;
	logic [63:0] res_q;
	logic        done_q;
	logic [31:0] mx;
	logic [31:0] my;
	logic [64:0] rem_sh;
	logic [64:0] rem_diff;

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    begin mx = a_q[31:0];  my = b_q[31:0];  end
			2'd1:    begin mx = a_q[31:0];  my = b_q[63:32]; end
			default: begin mx = a_q[63:32]; my = b_q[31:0];  end
		endcase
		rem_sh   = {rem_q, quo_q[63]};
		rem_diff = rem_sh - {1'b0, b_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if ((mul_q && cnt_q == 7'd3) || (!mul_q && cnt_q == 7'd64)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mul_q <= (op == OP_MUL);
			mod_q <= (op == OP_MOD);
			neg_q <= (op == OP_DIV) && (a[63] ^ b[63]);
			rem_q <= '0;
			res_q <= '0;
			if (op == OP_DIV) begin
				a_q   <= a[63] ? (64'd0 - a) : a;
				quo_q <= a[63] ? (64'd0 - a) : a;
				b_q   <= b[63] ? (64'd0 - b) : b;
			end else begin
				a_q   <= a;
				quo_q <= a;
				b_q   <= b;
			end
		end else if (busy_q) begin
			if (mul_q) begin
				prod_q <= mx * my;
				if (cnt_q == 7'd1)
					res_q <= prod_q;
				else if (cnt_q != 7'd0)
					res_q <= res_q + {prod_q[31:0], 32'd0};
			end else if (cnt_q != 7'd64) begin
				if (!rem_diff[64]) begin
					rem_q <= rem_diff[63:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_sh[63:0];
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end else begin
				res_q <= mod_q ? rem_q : (neg_q ? (64'd0 - quo_q) : quo_q);
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;
endmodule

// ----- rtl/dsm_ctrl.sv -----
// ----------------------------------------------------------------------------
// dsm_ctrl
// sequencer: accept, execute, wait for multiply or divide, commit
// ----------------------------------------------------------------------------
module dsm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dsm_pkg::dsm_stat_t stat,
	output dsm_pkg::dsm_cmd_t  cmd
);
	import dsm_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EXEC   = 2'd1;
	localparam logic [1:0] S_MD     = 2'd2;
	localparam logic [1:0] S_COMMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d      = state_q;
		cmd.accept   = 1'b0;
		cmd.md_start = 1'b0;
		cmd.commit   = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				if (stat.md_op && !stat.err) begin
					cmd.md_start = 1'b1;
					state_d      = S_MD;
				end else if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_MD: begin
				if (stat.md_done)
					state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign in_ready = (state_q == S_IDLE);

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> stat.out_free) else $error("commit while result slot full");
	a_md_follow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.md_start |=> (state_q == S_MD)) else $error("md start lost");
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == S_EXEC)) else $error("accept did not reach exec");
endmodule

// ----- rtl/dsm_dpath.sv -----
// ----------------------------------------------------------------------------
// dsm_dpath
// value stack with cached top and second entries, alu and result register
// ----------------------------------------------------------------------------
module dsm_dpath #(
	parameter int unsigned VS_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dsm_pkg::dsm_cmd_t  cmd,
	output dsm_pkg::dsm_stat_t stat,
	input  logic [4:0]         in_command,
	input  logic [63:0]        in_immediate,
	input  logic               cfg_we,
	input  logic [6:0]         cfg_data,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [63:0]        out_top_value,
	output logic [6:0]         out_stack_count,
	output logic               out_branch_taken,
	output logic [1:0]         out_status
);
	import dsm_pkg::*;

	localparam int unsigned PW = $clog2(VS_DEPTH + 1);
	localparam int unsigned AW = $clog2(VS_DEPTH);
	localparam int unsigned CW = (PW > CNT_W) ? PW : CNT_W;

	logic [63:0]   mem [VS_DEPTH];
	logic [63:0]   third_q;
	logic [63:0]   pick_q;
	logic [63:0]   top_q;
	logic [63:0]   sec_q;
	logic [PW-1:0] sp_q;
	logic [6:0]    limit_q;
	logic [4:0]    cmd_q;
	logic [63:0]   imm_q;
	logic          out_valid_q;
	logic [63:0]   out_top_q;
	logic [6:0]    out_cnt_q;
	logic          out_taken_q;
	logic [1:0]    out_sts_q;

	logic [1:0]    need;
	logic          is_push;
	logic [1:0]    sts;
	logic [63:0]   alu_r;
	logic [63:0]   bin_r;
	logic [63:0]   pick_v;
	logic          is_binary;
	logic [63:0]   nxt_top;
	logic [63:0]   nxt_sec;
	logic [PW-1:0] nxt_sp;
	logic          nxt_taken;
	logic          we;
	logic [AW-1:0] waddr;
	logic [63:0]   wdata;
	logic          md_done;
	logic [63:0]   md_res;

	dsm_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.md_start),
		.op     (cmd_q),
		.a      (sec_q),
		.b      (top_q),
		.done   (md_done),
		.result (md_res)
	);

	always_comb begin
		is_push = (cmd_q == OP_PUSH) || (cmd_q == OP_DUP) || (cmd_q == OP_OVER)
			|| (cmd_q == OP_PICK);
		if (cmd_q inside {OP_PUSH, OP_PICK, OP_CLEAR, OP_RSV0, OP_RSV1})
			need = 2'd0;
		else if (cmd_q inside {OP_DUP, OP_DROP, OP_ABS, OP_NEG, OP_NOT, OP_PLUSU, OP_BRA})
			need = 2'd1;
		else if (cmd_q == OP_ROT)
			need = 2'd3;
		else
			need = 2'd2;
		is_binary = cmd_q inside {OP_AND, OP_DIV, OP_MINUS, OP_MOD, OP_MUL, OP_OR, OP_PLUS,
			OP_SHL, OP_SHR, OP_SHRA, OP_XOR, OP_EQ, OP_GE, OP_GT, OP_LE, OP_LT, OP_NE};

		if (cmd_q == OP_PICK && imm_q >= 64'(sp_q))
			sts = ST_UNDER;
		else if (sp_q < PW'(need))
			sts = ST_UNDER;
		else if (is_push && (CW'(sp_q) >= CW'(limit_q) || sp_q >= PW'(VS_DEPTH)))
			sts = ST_OVER;
		else if ((cmd_q == OP_DIV || cmd_q == OP_MOD) && top_q == 64'd0)
			sts = ST_DIVZ;
		else
			sts = ST_OK;
	end

	always_comb begin
		case (cmd_q)
			OP_AND:   alu_r = sec_q & top_q;
			OP_MINUS: alu_r = sec_q - top_q;
			OP_OR:    alu_r = sec_q | top_q;
			OP_PLUS:  alu_r = sec_q + top_q;
			OP_XOR:   alu_r = sec_q ^ top_q;
			OP_SHL:   alu_r = (|top_q[63:6]) ? 64'd0 : (sec_q << top_q[5:0]);
			OP_SHR:   alu_r = (|top_q[63:6]) ? 64'd0 : (sec_q >> top_q[5:0]);
			OP_SHRA:  alu_r = (|top_q[63:6]) ? {64{sec_q[63]}}
				: 64'($signed(sec_q) >>> top_q[5:0]);
			OP_EQ:    alu_r = 64'(sec_q == top_q);
			OP_GE:    alu_r = 64'(!($signed(sec_q) < $signed(top_q)));
			OP_GT:    alu_r = 64'($signed(top_q) < $signed(sec_q));
			OP_LE:    alu_r = 64'(!($signed(top_q) < $signed(sec_q)));
			OP_LT:    alu_r = 64'($signed(sec_q) < $signed(top_q));
			default:  alu_r = 64'(sec_q != top_q);
		endcase
		bin_r = (cmd_q == OP_DIV || cmd_q == OP_MOD || cmd_q == OP_MUL) ? md_res : alu_r;

		if (imm_q[PW-1:0] == PW'(0))
			pick_v = top_q;
		else if (imm_q[PW-1:0] == PW'(1))
			pick_v = sec_q;
		else
			pick_v = pick_q;
	end

	always_comb begin
		nxt_top   = top_q;
		nxt_sec   = sec_q;
		nxt_sp    = sp_q;
		nxt_taken = 1'b0;
		we        = 1'b0;
		waddr     = AW'(sp_q - PW'(2));
		wdata     = sec_q;
		if (sts == ST_OK) begin
			if (is_push) begin
				we      = (sp_q >= PW'(2));
				nxt_sec = top_q;
				nxt_sp  = sp_q + PW'(1);
				case (cmd_q)
					OP_PUSH: nxt_top = imm_q;
					OP_DUP:  nxt_top = top_q;
					OP_OVER: nxt_top = sec_q;
					default: nxt_top = pick_v;
				endcase
			end else if (is_binary) begin
				nxt_top = bin_r;
				nxt_sec = third_q;
				nxt_sp  = sp_q - PW'(1);
			end else begin
				case (cmd_q)
					OP_DROP, OP_BRA: begin
						nxt_top   = sec_q;
						nxt_sec   = third_q;
						nxt_sp    = sp_q - PW'(1);
						nxt_taken = (cmd_q == OP_BRA) && (top_q != 64'd0);
					end
					OP_SWAP: begin
						nxt_top = sec_q;
						nxt_sec = top_q;
					end
					OP_ROT: begin
						nxt_top = sec_q;
						nxt_sec = third_q;
						we      = 1'b1;
						waddr   = AW'(sp_q - PW'(3));
						wdata   = top_q;
					end
					OP_ABS:   nxt_top = top_q[63] ? (64'd0 - top_q) : top_q;
					OP_NEG:   nxt_top = 64'd0 - top_q;
					OP_NOT:   nxt_top = ~top_q;
					OP_PLUSU: nxt_top = top_q + imm_q;
					OP_CLEAR: nxt_sp = '0;
					default:  nxt_top = top_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && we)
			mem[waddr] <= wdata;
		if (cmd.accept) begin
			third_q <= mem[AW'(sp_q - PW'(3))];
			pick_q  <= mem[AW'(sp_q - PW'(1) - in_immediate[PW-1:0])];
			cmd_q   <= in_command;
			imm_q   <= in_immediate;
		end
		if (cmd.commit) begin
			top_q       <= nxt_top;
			sec_q       <= nxt_sec;
			out_top_q   <= (nxt_sp == '0) ? 64'd0 : nxt_top;
			out_cnt_q   <= 7'(nxt_sp);
			out_taken_q <= nxt_taken;
			out_sts_q   <= sts;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			limit_q     <= LIMIT_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				limit_q <= cfg_data;
			if (cmd.commit) begin
				sp_q        <= nxt_sp;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.md_op    = (cmd_q == OP_DIV) || (cmd_q == OP_MOD) || (cmd_q == OP_MUL);
	assign stat.err      = (sts != ST_OK);
	assign stat.md_done  = md_done;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid        = out_valid_q;
	assign out_top_value    = out_top_q;
	assign out_stack_count  = out_cnt_q;
	assign out_branch_taken = out_taken_q;
	assign out_status       = out_sts_q;
endmodule

// ----- rtl/dwarf_stack_machine_execute.sv -----
// ----------------------------------------------------------------------------
// dwarf_stack_machine_execute
// execution unit of a 64-bit value stack machine
// ----------------------------------------------------------------------------
// instr carries one decoded instruction (command, immediate) per transfer;
// result returns one transfer per instruction with the new top, depth,
// branch flag and status. cfg writes the stack limit (reset value 64).
// one instruction is in flight at a time. most commands are accepted in the
// idle state and commit from the exec state once the result slot is free:
// the accept edge reads the stack memory, the exec state executes and commits.
// mul runs its three products through the shared 32x32 multiplier and div
// and mod run through the radix-2 divider before the commit state.
// the top two entries live in registers, deeper entries in a memory with
// two registered read ports.
// reset empties the stack and restores the limit; memory contents are kept.
// the result register holds a finished result while the receiver stalls and
// the next instruction is still taken; it waits to commit until the slot
// frees, and no further instruction is taken meanwhile.
// an erring instruction leaves the stack unchanged and reports its status.
// ----------------------------------------------------------------------------
module dwarf_stack_machine_execute #(
	parameter int unsigned VS_DEPTH = 64
) (
	input logic      clk,
	input logic      arst_n,
	dsm_in_if.sink   instr,
	dsm_out_if.source result,
	dsm_cfg_if.sink  cfg
);
	import dsm_pkg::*;

	dsm_cmd_t  cmd;
	dsm_stat_t stat;

	assign cfg.ready = 1'b1;

	dsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (instr.valid),
		.in_ready (instr.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dsm_dpath #(.VS_DEPTH(VS_DEPTH)) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.in_command       (instr.command),
		.in_immediate     (instr.immediate),
		.cfg_we           (cfg.valid),
		.cfg_data         (cfg.data),
		.out_ready        (result.ready),
		.out_valid        (result.valid),
		.out_top_value    (result.top_value),
		.out_stack_count  (result.stack_count),
		.out_branch_taken (result.branch_taken),
		.out_status       (result.status)
	);
endmodule
